FILE: rtl/mmp_pkg.sv
// Shared constants and register codes for the min/max pyramid builder.
`default_nettype none

package mmp_pkg;

   // Field widths fixed by the transaction format
   localparam int SAMPLE_BITS = 16;
   localparam int LEVEL_BITS  = 4;
   localparam int BLOCK_BITS  = 23;
   localparam int CFG_BITS    = 5;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_LEVELS = 16;
   localparam int DEF_COUNT_BITS = 24;

   // Depth of the queue between the classifier and the result serializer
   localparam int QUEUE_DEPTH = 4;

   // Lane values after reset and after a block is completed
   localparam logic signed [SAMPLE_BITS-1:0] MIN_INIT = 16'sh7FFF;
   localparam logic signed [SAMPLE_BITS-1:0] MAX_INIT = 16'sh8000;

   // Configuration port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [0:0] REG_LEVELS_IN_USE = 1'b0;
   localparam logic [CFG_BITS-1:0] LEVELS_RESET = 5'd16;

endpackage : mmp_pkg

`default_nettype wire

FILE: rtl/min_max_pyramid_builder.sv
// Top level of the min/max pyramid builder: configuration port, queue and both ends.
//
// Takes one signed 16-bit sample per cycle while req_stall is low, and keeps a running
// minimum and maximum for each of the levels in use, level j covering aligned blocks of
// 2^(j+1) samples. Each completed block (and, on a sample flagged last, every level in
// use) leaves as one result transaction, lowest level first, with last_result set on the
// final result of that sample. The serializer sends one result per cycle while rsp_stall
// is low; a sample that completes no block skips it. The four-entry queue behind the front
// end keeps taking samples until it fills. With the pipe idle, a sample's first result
// passes through the queue, the pending mask and the output register before it is valid.
// levels_in_use (register 0 at byte address 0) should be written only while the block is idle.
`default_nettype none

module min_max_pyramid_builder #(
   parameter int MAX_LEVELS = mmp_pkg::DEF_MAX_LEVELS,
   parameter int COUNT_BITS = mmp_pkg::DEF_COUNT_BITS
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   // Sample transactions
   input  wire logic                                     req_valid,
   output logic                                          req_stall,
   input  wire logic signed [mmp_pkg::SAMPLE_BITS-1:0]   req_sample,
   input  wire logic                                     req_last_sample,
   // Result transactions
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_stall,
   output logic [mmp_pkg::LEVEL_BITS-1:0]                rsp_level,
   output logic [mmp_pkg::BLOCK_BITS-1:0]                rsp_block_index,
   output logic signed [mmp_pkg::SAMPLE_BITS-1:0]        rsp_min_value,
   output logic signed [mmp_pkg::SAMPLE_BITS-1:0]        rsp_max_value,
   output logic                                          rsp_last_result,
   // Configuration
   input  wire logic                                     csr_psel,
   input  wire logic                                     csr_penable,
   input  wire logic                                     csr_pwrite,
   input  wire logic [mmp_pkg::CSR_ADDR_BITS-1:0]        csr_paddr,
   input  wire logic [mmp_pkg::CSR_DATA_BITS-1:0]        csr_pwdata,
   output logic [mmp_pkg::CSR_DATA_BITS-1:0]             csr_prdata,
   output logic                                          csr_pready
);
   import mmp_pkg::*;

   // Queue entry layout: sample, last flag, index, lane enables, done lanes
   localparam int ENTRY_BITS = SAMPLE_BITS + 1 + COUNT_BITS + 2 * MAX_LEVELS;

   logic [CFG_BITS-1:0]           levels_ff, levels_in;
   logic                          csr_write;
   logic [0:0]                    csr_reg;

   logic                          push;
   logic signed [SAMPLE_BITS-1:0] push_sample;
   logic                          push_last;
   logic [COUNT_BITS-1:0]         push_index;
   logic [MAX_LEVELS-1:0]         push_enable;
   logic [MAX_LEVELS-1:0]         push_done;
   logic [ENTRY_BITS-1:0]         push_data;
   logic                          queue_full;

   logic                          q_valid;
   logic                          q_pop;
   logic [ENTRY_BITS-1:0]         head_data;
   logic signed [SAMPLE_BITS-1:0] q_sample;
   logic                          q_last;
   logic [COUNT_BITS-1:0]         q_index;
   logic [MAX_LEVELS-1:0]         q_enable;
   logic [MAX_LEVELS-1:0]         q_done;

   // Register file: one 5-bit register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = csr_paddr[2:2];

   always_comb begin
      levels_in = levels_ff;
      if (csr_write && (csr_reg == REG_LEVELS_IN_USE)) begin
         levels_in = csr_pwdata[CFG_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= LEVELS_RESET;
      end else begin
         levels_ff <= levels_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_reg == REG_LEVELS_IN_USE) begin
         csr_prdata = {{(CSR_DATA_BITS-CFG_BITS){1'b0}}, levels_ff};
      end
   end

   mmp_front #(
      .MAX_LEVELS(MAX_LEVELS),
      .COUNT_BITS(COUNT_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .req_last_sample(req_last_sample),
      .levels_in_use  (levels_ff),
      .queue_full     (queue_full),
      .push           (push),
      .push_sample    (push_sample),
      .push_last      (push_last),
      .push_index     (push_index),
      .push_enable    (push_enable),
      .push_done      (push_done)
   );

   assign push_data = {push_sample, push_last, push_index, push_enable, push_done};

   mmp_queue #(
      .WIDTH(ENTRY_BITS),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .full     (queue_full),
      .pop      (q_pop),
      .not_empty(q_valid),
      .head_data(head_data)
   );

   assign {q_sample, q_last, q_index, q_enable, q_done} = head_data;

   mmp_back #(
      .MAX_LEVELS(MAX_LEVELS),
      .COUNT_BITS(COUNT_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_sample       (q_sample),
      .q_last         (q_last),
      .q_index        (q_index),
      .q_enable       (q_enable),
      .q_done         (q_done),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_level      (rsp_level),
      .rsp_block_index(rsp_block_index),
      .rsp_min_value  (rsp_min_value),
      .rsp_max_value  (rsp_max_value),
      .rsp_last_result(rsp_last_result)
   );

endmodule : min_max_pyramid_builder

`default_nettype wire

FILE: rtl/mmp_queue.sv
// Small FIFO that carries classified samples from the front end to the back end.
`default_nettype none

module mmp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = mmp_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  not_empty,
   output logic [WIDTH-1:0]      head_data
);
   import mmp_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    store_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = store_ff[rd_ptr_ff];

   // Pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full && !pop |-> !push)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CNT_BITS'(1))
      else $error("queue occupancy did not follow a lone write");

endmodule : mmp_queue

`default_nettype wire

FILE: rtl/mmp_front.sv
// Front end: accepts samples, tracks the sample index and marks completed levels.
`default_nettype none

module mmp_front #(
   parameter int MAX_LEVELS = mmp_pkg::DEF_MAX_LEVELS,
   parameter int COUNT_BITS = mmp_pkg::DEF_COUNT_BITS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic signed [mmp_pkg::SAMPLE_BITS-1:0] req_sample,
   input  wire logic                                   req_last_sample,
   input  wire logic [mmp_pkg::CFG_BITS-1:0]           levels_in_use,
   input  wire logic                                   queue_full,
   output logic                                        push,
   output logic signed [mmp_pkg::SAMPLE_BITS-1:0]      push_sample,
   output logic                                        push_last,
   output logic [COUNT_BITS-1:0]                       push_index,
   output logic [MAX_LEVELS-1:0]                       push_enable,
   output logic [MAX_LEVELS-1:0]                       push_done
);
   import mmp_pkg::*;

   logic [COUNT_BITS-1:0]            count_ff, count_in;
   logic                             saturated;
   logic [MAX_LEVELS+COUNT_BITS-1:0] index_ext;
   logic [MAX_LEVELS-1:0]            span_full;

   assign req_stall   = queue_full;
   assign push        = req_valid && !req_stall;
   assign saturated   = &count_ff;
   assign push_sample = req_sample;
   assign push_last   = req_last_sample;
   assign push_index  = count_ff;
   assign index_ext   = {{MAX_LEVELS{1'b0}}, count_ff};

   // Lane j is in use below the clamped level count; lane 0 always is
   always_comb begin
      for (int j = 0; j < MAX_LEVELS; j++) begin
         push_enable[j] = (j == 0) || (levels_in_use > CFG_BITS'(j));
      end
   end

   // Block at level j ends when the low j+1 index bits are all ones
   always_comb begin
      span_full[0] = index_ext[0];
      for (int j = 1; j < MAX_LEVELS; j++) begin
         span_full[j] = span_full[j-1] & index_ext[j];
      end
   end

   assign push_done = push_enable & ({MAX_LEVELS{req_last_sample}}
                    | ({MAX_LEVELS{!saturated}} & span_full));

   // Sample index: restarts after the last sample, holds once saturated
   always_comb begin
      count_in = count_ff;
      if (push) begin
         if (req_last_sample) begin
            count_in = '0;
         end else if (!saturated) begin
            count_in = count_ff + COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_done_in_use: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_done & ~push_enable) == '0)
      else $error("block marked done on a lane not in use");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      push && req_last_sample |=> count_ff == '0)
      else $error("sample index not restarted after last sample");

   a_saturated_holds: assert property (@(posedge clock) disable iff (reset)
      push && saturated && !req_last_sample |=> $stable(count_ff))
      else $error("saturated sample index moved");

endmodule : mmp_front

`default_nettype wire

FILE: rtl/mmp_back.sv
// Back end: per-level min/max lanes and the serializer that emits completed blocks.
`default_nettype none

module mmp_back #(
   parameter int MAX_LEVELS = mmp_pkg::DEF_MAX_LEVELS,
   parameter int COUNT_BITS = mmp_pkg::DEF_COUNT_BITS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   q_valid,
   output logic                                        q_pop,
   input  wire logic signed [mmp_pkg::SAMPLE_BITS-1:0] q_sample,
   input  wire logic                                   q_last,
   input  wire logic [COUNT_BITS-1:0]                  q_index,
   input  wire logic [MAX_LEVELS-1:0]                  q_enable,
   input  wire logic [MAX_LEVELS-1:0]                  q_done,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [mmp_pkg::LEVEL_BITS-1:0]              rsp_level,
   output logic [mmp_pkg::BLOCK_BITS-1:0]              rsp_block_index,
   output logic signed [mmp_pkg::SAMPLE_BITS-1:0]      rsp_min_value,
   output logic signed [mmp_pkg::SAMPLE_BITS-1:0]      rsp_max_value,
   output logic                                        rsp_last_result
);
   import mmp_pkg::*;

   localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

   // Running lanes
   logic signed [SAMPLE_BITS-1:0] lane_min_ff [MAX_LEVELS];
   logic signed [SAMPLE_BITS-1:0] lane_max_ff [MAX_LEVELS];
   logic signed [SAMPLE_BITS-1:0] lane_min_in [MAX_LEVELS];
   logic signed [SAMPLE_BITS-1:0] lane_max_in [MAX_LEVELS];
   logic signed [SAMPLE_BITS-1:0] upd_min     [MAX_LEVELS];
   logic signed [SAMPLE_BITS-1:0] upd_max     [MAX_LEVELS];

   // Finished blocks waiting for the output
   logic signed [SAMPLE_BITS-1:0] cap_min_ff [MAX_LEVELS];
   logic signed [SAMPLE_BITS-1:0] cap_max_ff [MAX_LEVELS];
   logic [MAX_LEVELS-1:0]         pending_ff, pending_in;
   logic [COUNT_BITS-1:0]         index_ff;

   // Serializer select
   logic [MAX_LEVELS-1:0]            low_bit;
   logic [MAX_LEVELS-1:0]            rest;
   logic [LVL_W-1:0]                 low_idx;
   logic [LVL_W:0]                   shift_amt;
   logic [COUNT_BITS-1:0]            index_shifted;
   logic [COUNT_BITS+BLOCK_BITS-1:0] index_wide;
   logic                             out_free;
   logic                             pop_result;

   // Output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_BITS-1:0]         level_ff;
   logic [BLOCK_BITS-1:0]         block_ff;
   logic signed [SAMPLE_BITS-1:0] min_ff;
   logic signed [SAMPLE_BITS-1:0] max_ff;
   logic                          last_ff;

   // Lowest pending level goes out first
   always_comb begin
      low_bit = pending_ff & (~pending_ff + MAX_LEVELS'(1));
      low_idx = '0;
      for (int j = 0; j < MAX_LEVELS; j++) begin
         if (low_bit[j]) begin
            low_idx = low_idx | LVL_W'(j);
         end
      end
   end

   assign rest       = pending_ff & ~low_bit;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign pop_result = (pending_ff != '0) && out_free;
   assign q_pop      = q_valid && ((pending_ff == '0) || (pop_result && (rest == '0)));

   assign shift_amt     = {1'b0, low_idx} + (LVL_W+1)'(1);
   assign index_shifted = index_ff >> shift_amt;
   assign index_wide    = {{BLOCK_BITS{1'b0}}, index_shifted};

   // Lane update for the sample taken from the queue
   always_comb begin
      for (int j = 0; j < MAX_LEVELS; j++) begin
         upd_min[j] = (q_enable[j] && (q_sample < lane_min_ff[j])) ? q_sample : lane_min_ff[j];
         upd_max[j] = (q_enable[j] && (q_sample > lane_max_ff[j])) ? q_sample : lane_max_ff[j];
         lane_min_in[j] = lane_min_ff[j];
         lane_max_in[j] = lane_max_ff[j];
         if (q_pop) begin
            if (q_done[j] || q_last) begin
               lane_min_in[j] = MIN_INIT;
               lane_max_in[j] = MAX_INIT;
            end else begin
               lane_min_in[j] = upd_min[j];
               lane_max_in[j] = upd_max[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_LEVELS; j++) begin
            lane_min_ff[j] <= MIN_INIT;
            lane_max_ff[j] <= MAX_INIT;
         end
      end else begin
         for (int j = 0; j < MAX_LEVELS; j++) begin
            lane_min_ff[j] <= lane_min_in[j];
            lane_max_ff[j] <= lane_max_in[j];
         end
      end
   end

   // Capture finished blocks and their sample index
   always_ff @(posedge clock) begin
      if (q_pop) begin
         index_ff <= q_index;
         for (int j = 0; j < MAX_LEVELS; j++) begin
            if (q_done[j]) begin
               cap_min_ff[j] <= upd_min[j];
               cap_max_ff[j] <= upd_max[j];
            end
         end
      end
   end

   // Pending mask
   always_comb begin
      pending_in = pending_ff;
      if (q_pop) begin
         pending_in = q_done;
      end else if (pop_result) begin
         pending_in = rest;
      end
   end

   // Output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop_result) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_result) begin
         level_ff <= LEVEL_BITS'(low_idx);
         block_ff <= index_wide[BLOCK_BITS-1:0];
         min_ff   <= cap_min_ff[low_idx];
         max_ff   <= cap_max_ff[low_idx];
         last_ff  <= (rest == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_level       = level_ff;
   assign rsp_block_index = block_ff;
   assign rsp_min_value   = min_ff;
   assign rsp_max_value   = max_ff;
   assign rsp_last_result = last_ff;

   a_pop_shows: assert property (@(posedge clock) disable iff (reset)
      pop_result |=> rsp_valid_ff)
      else $error("popped block did not reach the output register");

   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> pending_ff == $past(q_done))
      else $error("pending mask not loaded from the taken sample");

   a_more_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !last_ff |-> pending_ff != '0)
      else $error("non-final transaction shown with nothing left pending");

endmodule : mmp_back

`default_nettype wire
